/* src/assert_macros.svh */
// Assertion macros used by host_command_packet_parser.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge outside reset.
`define HCPP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hcpp assertion failed");
// Property checked on every rising clock edge, reset included.
`define HCPP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("hcpp assertion failed");
`else
`define HCPP_ASSERT(name, clk, rstn, prop)
`define HCPP_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

/* src/hcpp_pkg.sv */
// Types and constants of the host command packet parser.
package hcpp_pkg;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       end_of_packet;
    logic       empty_packet;
  } hcpp_in_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  message_kind;
    logic [1:0]  error_code;
    logic [15:0] start_address;
    logic [7:0]  read_length;
    logic [7:0]  data_byte;
    logic        last_result;
  } hcpp_out_t;

  // Results produced by one item, handed to the output queue.
  typedef struct packed {
    logic [1:0] cnt;
    hcpp_out_t  r0;
    hcpp_out_t  r1;
  } hcpp_push_t;

  localparam logic [7:0] OP_READ   = 8'h00;
  localparam logic [7:0] OP_WRITE  = 8'h01;
  localparam logic [7:0] OP_LOCK   = 8'h02;
  localparam logic [7:0] OP_UNLOCK = 8'h03;
  localparam logic [7:0] OP_ERASE  = 8'h04;
  localparam logic [7:0] OP_EXIT   = 8'hFF;

  localparam logic [2:0] MK_READ  = 3'd0;
  localparam logic [2:0] MK_WRITE = 3'd1;
  localparam logic [2:0] MK_EXIT  = 3'd5;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_EMPTY      = 2'd1;
  localparam logic [1:0] ERR_MALFORMED  = 2'd2;
  localparam logic [1:0] ERR_INVALID_OP = 2'd3;

  localparam logic RK_SUMMARY = 1'b0;
  localparam logic RK_DATA    = 1'b1;

  localparam logic [2:0] POS_OPCODE = 3'd0;
  localparam logic [2:0] POS_ADDR_HI = 3'd1;
  localparam logic [2:0] POS_ADDR_LO = 3'd2;
  localparam logic [2:0] POS_LENGTH = 3'd3;
  localparam logic [2:0] POS_MAX = 3'd7;

  localparam logic [2:0] READ_TOTAL  = 3'd4;
  localparam logic [2:0] WRITE_MIN   = 3'd3;
  localparam logic [2:0] SHORT_TOTAL = 3'd1;

endpackage

/* src/hcpp_parse.sv */
// Input register, packet state and per-byte result decode.
module hcpp_parse import hcpp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  hcpp_in_t   in_data_i,
  input  logic       room_i,
  output hcpp_push_t push_o
);

  logic        in_valid_q;
  hcpp_in_t    in_q;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  op_q, op_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  len_q, len_d;
  logic        proc;
  logic        data_res;
  logic [2:0]  total;
  hcpp_out_t   summ;
  hcpp_out_t   data_r;

  assign proc       = in_valid_q && room_i;
  assign in_ready_o = !in_valid_q || room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  always_comb begin
    op_d   = op_q;
    addr_d = addr_q;
    len_d  = len_q;
    unique case (pos_q)
      POS_OPCODE:  op_d = in_q.packet_byte;
      POS_ADDR_HI: addr_d = {in_q.packet_byte, addr_q[7:0]};
      POS_ADDR_LO: addr_d = {addr_q[15:8], in_q.packet_byte};
      POS_LENGTH:  len_d = in_q.packet_byte;
      default: ;
    endcase

    total    = (pos_q == POS_MAX) ? POS_MAX : pos_q + 3'd1;
    data_res = (op_d == OP_WRITE) && (pos_q >= POS_LENGTH);

    data_r               = '0;
    data_r.result_kind   = RK_DATA;
    data_r.message_kind  = MK_WRITE;
    data_r.error_code    = ERR_NONE;
    data_r.start_address = addr_d;
    data_r.data_byte     = in_q.packet_byte;
    data_r.last_result   = !in_q.end_of_packet;

    summ             = '0;
    summ.result_kind = RK_SUMMARY;
    summ.last_result = 1'b1;
    if (in_q.empty_packet) begin
      summ.error_code = ERR_EMPTY;
    end else if (op_d == OP_READ) begin
      if (total != READ_TOTAL) begin
        summ.error_code = ERR_MALFORMED;
      end else begin
        summ.message_kind  = MK_READ;
        summ.start_address = addr_d;
        summ.read_length   = len_d;
      end
    end else if (op_d == OP_WRITE) begin
      if (total < WRITE_MIN) begin
        summ.error_code = ERR_MALFORMED;
      end else begin
        summ.message_kind  = MK_WRITE;
        summ.start_address = addr_d;
      end
    end else if (op_d == OP_LOCK || op_d == OP_UNLOCK || op_d == OP_ERASE
                 || op_d == OP_EXIT) begin
      if (total != SHORT_TOTAL) begin
        summ.error_code = ERR_MALFORMED;
      end else begin
        summ.message_kind = (op_d == OP_EXIT) ? MK_EXIT : op_d[2:0];
      end
    end else begin
      summ.error_code = ERR_INVALID_OP;
    end

    push_o = '0;
    if (proc) begin
      if (in_q.empty_packet) begin
        push_o.cnt = 2'd1;
        push_o.r0  = summ;
      end else if (data_res) begin
        push_o.r0  = data_r;
        push_o.r1  = summ;
        push_o.cnt = in_q.end_of_packet ? 2'd2 : 2'd1;
      end else if (in_q.end_of_packet) begin
        push_o.cnt = 2'd1;
        push_o.r0  = summ;
      end
    end

    pos_d = total;
    // drop all packet state at packet end or on an empty item
    if (in_q.empty_packet || in_q.end_of_packet) begin
      pos_d  = '0;
      op_d   = '0;
      addr_d = '0;
      len_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      op_q   <= '0;
      addr_q <= '0;
      len_q  <= '0;
    end else if (proc) begin
      pos_q  <= pos_d;
      op_q   <= op_d;
      addr_q <= addr_d;
      len_q  <= len_d;
    end
  end

endmodule

/* src/hcpp_fifo.sv */
// Result queue: takes up to two results a cycle, gives one while out_ready_i is high.
module hcpp_fifo import hcpp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  hcpp_push_t                 push_i,
  output logic                       room_o,
  output logic [$clog2(Depth+1)-1:0] level_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hcpp_out_t                  out_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  hcpp_out_t             mem_q [Depth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, wr_ptr1, rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]       level_q, level_d;
  logic                  pop;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (level_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign room_o      = (level_q <= LvlW'(Depth - 2));
  assign level_o     = level_q;

  always_comb begin
    wr_ptr1  = wrap_inc(wr_ptr_q);
    wr_ptr_d = wr_ptr_q;
    unique case (push_i.cnt)
      2'd1:    wr_ptr_d = wr_ptr1;
      2'd2:    wr_ptr_d = wrap_inc(wr_ptr1);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop ? wrap_inc(rd_ptr_q) : rd_ptr_q;
    level_d  = level_q + LvlW'(push_i.cnt) - LvlW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

endmodule

/* src/host_command_packet_parser.sv */
// Host command packet parser: takes one packet byte per cycle (opcode, address high, address
// low, then read length for a read or payload for a write) and gives one summary item at
// packet end or on an empty item, preceded by a write-data item for each write payload byte.
// One input item is accepted every cycle while the result queue has room for two results; a
// result is held in the input register and then in the queue memory before it appears. The
// queue drains one item per cycle while out_ready_i is high. OutDepth sets the queue depth.
`include "assert_macros.svh"
module host_command_packet_parser import hcpp_pkg::*; #(
  parameter int unsigned OutDepth = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hcpp_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hcpp_out_t out_data_o
);

  hcpp_push_t                    push;
  logic                          room;
  logic [$clog2(OutDepth+1)-1:0] level;

  hcpp_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .room_i     (room),
    .push_o     (push)
  );

  hcpp_fifo #(
    .Depth (OutDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .level_o     (level),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `HCPP_ASSERT(a_level_bound, clk_i, rst_ni, level <= ($clog2(OutDepth+1))'(OutDepth))
  `HCPP_ASSERT(a_push_fits, clk_i, rst_ni,
    push.cnt != 2'd0 |-> level <= ($clog2(OutDepth+1))'(OutDepth - 2))
  `HCPP_ASSERT(a_pair_order, clk_i, rst_ni,
    push.cnt == 2'd2 |-> push.r0.result_kind == RK_DATA && !push.r0.last_result
      && push.r1.result_kind == RK_SUMMARY)
  `HCPP_ASSERT(a_summary_last, clk_i, rst_ni,
    out_valid_o && out_data_o.result_kind == RK_SUMMARY |-> out_data_o.last_result)

endmodule
